// ----- rtl/gtb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtb_pkg
// Shared types, fixed-point constants and helper functions for the
// tanh-approximated GELU backward datapath.
// ----------------------------------------------------------------------------
package gtb_pkg;

   // external number format: signed Q4.12
   localparam int DATA_W    = 16;
   localparam int FRAC_BITS = 12;

   // internal working format: Q26 in signed words
   localparam int WF        = 26;
   localparam int X_SHIFT   = WF - FRAC_BITS;
   localparam int TAIL_LIM  = 5 << FRAC_BITS;

   // pipeline shape
   localparam int STAGES      = 12;
   localparam int TANH_STAGES = 3;

   // internal widths, sized from the value ranges with |x| < 5
   localparam int X_W    = 30;
   localparam int X2_W   = 32;
   localparam int X3_W   = 35;
   localparam int POLY_W = 30;
   localparam int V_W    = 31;
   localparam int U_W    = 32;
   localparam int T_W    = 28;
   localparam int XS_W   = 30;
   localparam int D2_W   = 33;

   localparam logic signed [63:0] ONE_Q   = 64'sd67108864;
   localparam logic signed [63:0] K_Q     = 64'sd53545126;
   localparam logic signed [63:0] C_Q     = 64'sd3000773;
   localparam logic signed [63:0] C3_Q    = 64'sd7182811;
   localparam logic signed [63:0] OUT_MAX = 64'sd32767;
   localparam logic signed [63:0] OUT_MIN = -64'sd32768;

   localparam logic signed [T_W-1:0] ONE_T = T_W'(ONE_Q);

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [TANH_STAGES-1:0]   tanh_en_type;

   // Round half up, then arithmetic shift right.
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int s);
      rnd_shift = (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // Unsigned shift-and-subtract quotient, only for building constant tables.
   function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] rem;
      q   = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], n[i]};
         if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      udiv = q;
   endfunction

   // tanh(8k/segs) in Q26, built with integer steps only (elaboration time).
   // exp(-32z) is a 24-term series for exp(-z) raised to the 32nd power by
   // five squarings, all in Q30.
   function automatic logic [63:0] tanh_entry(input int k, input int segs);
      logic [63:0] one;
      logic [63:0] half;
      logic [63:0] seg2;
      logic [63:0] z;
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] den;
      logic [63:0] num;
      one  = 64'd1 << 30;
      half = 64'd1 << 29;
      seg2 = 64'(segs) << 1;
      z    = udiv((64'(k) << 30) + (seg2 >> 1), seg2);
      sum  = one;
      term = one;
      for (int n = 1; n <= 24; n++) begin
         term = udiv((term * z + half) >> 30, 64'(n));
         if ((n & 1) != 0) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      for (int i = 0; i < 5; i++) begin
         sum = (sum * sum + half) >> 30;
      end
      if (sum > one) begin
         sum = one;
      end
      den = one + sum;
      num = (one - sum) << WF;
      tanh_entry = udiv(num + (den >> 1), den);
   endfunction

endpackage

// ----- rtl/gtb_intf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtb_intf
// Valid/ready channels: request (activation, gradient) and response
// (input gradient).
// ----------------------------------------------------------------------------
interface gtb_req_if;
   import gtb_pkg::*;

   logic     valid;
   logic     ready;
   data_type activation;
   data_type upstream_grad;

   modport source (output valid, output activation, output upstream_grad, input ready);
   modport sink   (input valid, input activation, input upstream_grad, output ready);
endinterface

interface gtb_rsp_if;
   import gtb_pkg::*;

   logic     valid;
   logic     ready;
   data_type input_grad;

   modport source (output valid, output input_grad, input ready);
   modport sink   (input valid, input input_grad, output ready);
endinterface

// ----- rtl/gelu_tanh_backward.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gelu_tanh_backward
// Gradient of tanh-approximated GELU: input_grad = upstream_grad * GELU'(x),
// signed Q4.12 in and out, saturated.
//
//   channel   dir   handshake      payload
//   req_ch    in    valid/ready    activation, upstream_grad  (Q4.12)
//   rsp_ch    out   valid/ready    input_grad                 (Q4.12)
//
// One item per cycle sustained while rsp_ch.ready stays high; an accepted item
// moves through the stages in order, and rsp_ch.valid rises once it is in the last.
// The datapath has 12 register stages, at most one multiply deep each.
// Reset clears only the stage valid bits.
// A stage holds while the stage after it is full and not moving; empty stages
// keep filling, so a waiting result blocks new items only once all are full.
// ----------------------------------------------------------------------------
module gelu_tanh_backward #(
   parameter int TANH_SEGMENTS = 64
) (
   input  logic       clock,
   input  logic       reset,
   gtb_req_if.sink    req_ch,
   gtb_rsp_if.source  rsp_ch
);
   import gtb_pkg::*;

   logic [STAGES:1] vld_ff;
   logic [STAGES:1] en;
   logic            in_acc;
   logic            out_acc;

   // carried operands, indexed by stage
   logic signed [X_W-1:0]    x_ff    [1:9];
   data_type                 g_ff    [1:11];
   logic                     hi_ff   [1:10];
   logic                     lo_ff   [1:10];
   logic signed [POLY_W-1:0] poly_ff [3:10];
   logic signed [T_W-1:0]    t_ff    [9:10];

   logic signed [X2_W-1:0]   x2_ff;
   logic signed [X3_W-1:0]   x3_ff;
   logic signed [V_W-1:0]    v_ff;
   logic signed [U_W-1:0]    u_ff;
   logic signed [T_W-1:0]    sech2_ff;
   logic signed [XS_W-1:0]   xs_ff;
   logic signed [D2_W-1:0]   d2_ff;
   data_type                 out_ff;

   int                       act_i;
   logic                     hi1_in;
   logic                     lo1_in;
   logic signed [X_W-1:0]    x1_in;
   logic signed [X2_W-1:0]   x2_in;
   logic signed [X3_W-1:0]   x3_in;
   logic signed [POLY_W-1:0] poly_in;
   logic signed [V_W-1:0]    v_in;
   logic signed [U_W-1:0]    u_in;
   logic signed [T_W-1:0]    tanh_t;
   logic signed [T_W-1:0]    sech2_in;
   logic signed [XS_W-1:0]   xs_in;
   logic signed [D2_W-1:0]   d2_in;
   logic signed [63:0]       r;
   data_type                 out_in;

   // stage moves when it is empty or the next one moves
   always_comb begin
      en[STAGES] = !vld_ff[STAGES] || rsp_ch.ready;
      for (int i = STAGES - 1; i >= 1; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   assign req_ch.ready     = en[1];
   assign rsp_ch.valid     = vld_ff[STAGES];
   assign rsp_ch.input_grad = out_ff;
   assign in_acc           = req_ch.valid && req_ch.ready;
   assign out_acc          = rsp_ch.valid && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[1]) begin
            vld_ff[1] <= req_ch.valid;
         end
         for (int i = 2; i <= STAGES; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_comb begin
      act_i  = int'(req_ch.activation);
      hi1_in = act_i >= TAIL_LIM;
      lo1_in = act_i <= -TAIL_LIM;
      // far tails bypass the polynomial; zero x keeps it in range
      x1_in  = (hi1_in || lo1_in) ? '0 : X_W'(req_ch.activation) <<< X_SHIFT;

      x2_in   = X2_W'(rnd_shift(64'(x_ff[1]) * 64'(x_ff[1]), WF));
      x3_in   = X3_W'(rnd_shift(64'(x2_ff) * 64'(x_ff[2]), WF));
      poly_in = POLY_W'(K_Q + rnd_shift(C3_Q * 64'(x2_ff), WF));
      v_in    = V_W'(64'(x_ff[3]) + rnd_shift(C_Q * 64'(x3_ff), WF));
      u_in    = U_W'(rnd_shift(K_Q * 64'(v_ff), WF));

      sech2_in = T_W'(ONE_Q - rnd_shift(64'(tanh_t) * 64'(tanh_t), WF));
      xs_in    = XS_W'(rnd_shift(64'(x_ff[9]) * 64'(sech2_ff), WF));

      // twice the derivative
      priority if (hi_ff[10]) begin
         d2_in = D2_W'(ONE_Q <<< 1);
      end else if (lo_ff[10]) begin
         d2_in = '0;
      end else begin
         d2_in = D2_W'(ONE_Q + 64'(t_ff[10]) +
                       rnd_shift(64'(xs_ff) * 64'(poly_ff[10]), WF));
      end

      r = rnd_shift(64'(g_ff[11]) * 64'(d2_ff), WF + 1);
      priority if (r > OUT_MAX) begin
         out_in = DATA_W'(OUT_MAX);
      end else if (r < OUT_MIN) begin
         out_in = DATA_W'(OUT_MIN);
      end else begin
         out_in = DATA_W'(r);
      end
   end

   gtb_tanh #(
      .SEGMENTS (TANH_SEGMENTS)
   ) u_tanh (
      .clock    (clock),
      .stage_en (en[8:6]),
      .u        (u_ff),
      .t        (tanh_t)
   );

   always_ff @(posedge clock) begin
      if (en[1]) begin
         x_ff[1]  <= x1_in;
         g_ff[1]  <= req_ch.upstream_grad;
         hi_ff[1] <= hi1_in;
         lo_ff[1] <= lo1_in;
      end
      if (en[2]) begin
         x2_ff <= x2_in;
      end
      if (en[3]) begin
         x3_ff      <= x3_in;
         poly_ff[3] <= poly_in;
      end
      if (en[4]) begin
         v_ff <= v_in;
      end
      if (en[5]) begin
         u_ff <= u_in;
      end
      if (en[9]) begin
         sech2_ff <= sech2_in;
         t_ff[9]  <= tanh_t;
      end
      if (en[10]) begin
         xs_ff    <= xs_in;
         t_ff[10] <= t_ff[9];
      end
      if (en[11]) begin
         d2_ff <= d2_in;
      end
      if (en[12]) begin
         out_ff <= out_in;
      end
      for (int i = 2; i <= 9; i++) begin
         if (en[i]) begin
            x_ff[i] <= x_ff[i-1];
         end
      end
      for (int i = 2; i <= 11; i++) begin
         if (en[i]) begin
            g_ff[i] <= g_ff[i-1];
         end
      end
      for (int i = 2; i <= 10; i++) begin
         if (en[i]) begin
            hi_ff[i] <= hi_ff[i-1];
            lo_ff[i] <= lo_ff[i-1];
         end
      end
      for (int i = 4; i <= 10; i++) begin
         if (en[i]) begin
            poly_ff[i] <= poly_ff[i-1];
         end
      end
   end

   // items in flight change only by accepts and deliveries
   a_item_count: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(vld_ff) ==
                $countones($past(vld_ff)) + int'($past(in_acc)) - int'($past(out_acc))))
      else $error("item count in pipeline broken");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      in_acc |=> vld_ff[1])
      else $error("accepted item missing from first stage");

   a_free_slot: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[STAGES] |-> req_ch.ready)
      else $error("input stalled with output stage empty");

   a_tanh_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[9] |-> (t_ff[9] <= ONE_T && t_ff[9] >= -ONE_T))
      else $error("tanh outside [-1, 1]");

endmodule

// ----- rtl/gtb_tanh.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtb_tanh
// Three-stage piecewise-linear tanh on Q26: segment select, table read,
// interpolation. Odd extension for negative input, clamps to one at |u| >= 8.
// ----------------------------------------------------------------------------
module gtb_tanh #(
   parameter int SEGMENTS = 64
) (
   input  logic                             clock,
   input  gtb_pkg::tanh_en_type             stage_en,
   input  logic signed [gtb_pkg::U_W-1:0]   u,
   output logic signed [gtb_pkg::T_W-1:0]   t
);
   import gtb_pkg::*;

   localparam int POS_W  = WF + 3;              // position within [0, 8)
   localparam int IDX_W  = $clog2(SEGMENTS);
   localparam int NUM_W  = POS_W + IDX_W;
   localparam int TAB_IW = $clog2(SEGMENTS + 1);

   logic signed [T_W-1:0] tab [SEGMENTS+1];

   for (genvar k = 0; k <= SEGMENTS; k++) begin : g_tab
      localparam logic signed [T_W-1:0] ENTRY = T_W'(tanh_entry(k, SEGMENTS));
      assign tab[k] = ENTRY;
   end

   // stage A: magnitude and segment
   logic [U_W-1:0]         mag;
   logic [NUM_W-1:0]       num;
   logic [IDX_W-1:0]       idx_ff;
   logic signed [POS_W:0]  rem_ff;
   logic                   sat_ff;
   logic                   neg_ff;

   // stage B: table values
   logic signed [T_W-1:0]  lo_in;
   logic signed [T_W-1:0]  diff_in;
   logic signed [T_W-1:0]  lo_ff;
   logic signed [T_W-1:0]  diff_ff;
   logic signed [POS_W:0]  rem2_ff;
   logic                   sat2_ff;
   logic                   neg2_ff;

   // stage C: interpolation
   logic signed [63:0]     interp;
   logic signed [T_W-1:0]  tmag;
   logic signed [T_W-1:0]  t_in;
   logic signed [T_W-1:0]  t_ff;

   always_comb begin
      mag     = u[U_W-1] ? U_W'(-u) : U_W'(u);
      num     = NUM_W'(mag[POS_W-1:0]) * NUM_W'(SEGMENTS);
      lo_in   = tab[TAB_IW'(idx_ff)];
      diff_in = tab[TAB_IW'(idx_ff) + TAB_IW'(1)] - lo_in;
      interp  = 64'(lo_ff) + rnd_shift(64'(diff_ff) * 64'(rem2_ff), POS_W);
      tmag    = sat2_ff ? ONE_T : T_W'(interp);
      t_in    = neg2_ff ? -tmag : tmag;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         idx_ff <= num[NUM_W-1:POS_W];
         rem_ff <= {1'b0, num[POS_W-1:0]};
         sat_ff <= |mag[U_W-1:POS_W];
         neg_ff <= u[U_W-1];
      end
      if (stage_en[1]) begin
         lo_ff   <= lo_in;
         diff_ff <= diff_in;
         rem2_ff <= rem_ff;
         sat2_ff <= sat_ff;
         neg2_ff <= neg_ff;
      end
      if (stage_en[2]) begin
         t_ff <= t_in;
      end
   end

   assign t = t_ff;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for gelu_tanh_backward. A directed set and about 1250
// random (activation, gradient) items are streamed in bursts while the
// response side stalls on its own pattern. Every response is compared
// against a bit-true Q26 predictor of the GELU derivative times the gradient.
// ----------------------------------------------------------------------------
module tb_top;
   import gtb_pkg::*;

   localparam int CLK_PERIOD   = 8;
   localparam int RESET_CYCLES = 7;
   localparam int PIPE_LAT     = 12;
   localparam int IDLE_LIMIT   = 2000;
   localparam int N_RANDOM     = 1250;
   localparam int SEGS         = 64;

   // Q26 working format
   localparam int     QF       = 26;
   localparam int     TANH_SH  = QF + 3;   // tanh table spans [0, 8)
   localparam longint Q_ONE    = 64'sd1 <<< QF;
   localparam longint Q_K      = 64'sd53545126;
   localparam longint Q_C      = 64'sd3000773;
   localparam longint Q_C3     = 64'sd7182811;
   localparam longint TAIL_X   = 64'sd5 <<< 12;
   localparam longint SAT_HI   = 64'sd32767;
   localparam longint SAT_LO   = -64'sd32768;

   typedef struct {
      data_type act;
      data_type grad;
   } gelu_pair_type;

   typedef enum logic [1:0] {RDY_ALWAYS, RDY_RANDOM, RDY_SPARSE, RDY_PATTERN} rdy_mode_type;

   logic clock = 1'b0;
   logic reset;

   gtb_req_if req_ch ();
   gtb_rsp_if rsp_ch ();

   gelu_tanh_backward #(
      .TANH_SEGMENTS(SEGS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   longint        tanh_knots [0:SEGS];
   gelu_pair_type pairs_q [$];
   data_type      grad_expected_q [$];

   int  n_total;
   int  n_accepted;
   int  n_checked;
   int  n_errors;
   int  n_saturated;
   int  n_tail;
   int  idle_cycles;
   bit  req_fired;

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic longint shift_round(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint q26_mul(longint a, longint b);
      return shift_round(a * b, QF);
   endfunction

   // tanh(8k/SEGS) in Q26; exp(-32z) from a series, squared five times, Q30
   task automatic build_tanh_knots();
      longint unsigned e_one, e_half, seg2, z, sum, term, den, num;
      e_one  = 64'd1 << 30;
      e_half = 64'd1 << 29;
      seg2   = 2 * SEGS;
      for (longint unsigned k = 0; k <= SEGS; k++) begin
         z    = ((k << 30) + seg2 / 2) / seg2;
         sum  = e_one;
         term = e_one;
         for (int n = 1; n <= 24; n++) begin
            term = ((term * z + e_half) >> 30) / longint'(n);
            if (n % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         for (int i = 0; i < 5; i++) begin
            sum = (sum * sum + e_half) >> 30;
         end
         if (sum > e_one) begin
            sum = e_one;
         end
         den = e_one + sum;
         num = (e_one - sum) << QF;
         tanh_knots[k] = longint'((num + den / 2) / den);
      end
   endtask

   function automatic longint tanh_lookup(longint u);
      longint mag, num, rem, t;
      int     idx;
      mag = (u < 0) ? -u : u;
      if (mag >= (64'sd1 <<< TANH_SH)) begin
         t = Q_ONE;
      end else begin
         num = mag * SEGS;
         idx = int'(num >>> TANH_SH);
         if (idx >= SEGS) begin
            idx = SEGS - 1;
         end
         rem = num & ((64'sd1 <<< TANH_SH) - 1);
         t   = tanh_knots[idx]
               + shift_round((tanh_knots[idx + 1] - tanh_knots[idx]) * rem, TANH_SH);
      end
      return (u < 0) ? -t : t;
   endfunction

   function automatic data_type gelu_grad_q412(data_type act, data_type grad);
      longint a, g, x, x2, x3, u, t, sech2, poly, d2, r;
      a = act;
      g = grad;
      if (a >= TAIL_X) begin
         d2 = 2 * Q_ONE;
      end else if (a <= -TAIL_X) begin
         d2 = 0;
      end else begin
         x     = a <<< (QF - 12);
         x2    = q26_mul(x, x);
         x3    = q26_mul(x2, x);
         u     = q26_mul(Q_K, x + q26_mul(Q_C, x3));
         t     = tanh_lookup(u);
         sech2 = Q_ONE - q26_mul(t, t);
         poly  = Q_K + q26_mul(Q_C3, x2);
         d2    = Q_ONE + t + q26_mul(q26_mul(x, sech2), poly);
      end
      r = shift_round(g * d2, QF + 1);
      if (r > SAT_HI) begin
         r = SAT_HI;
      end
      if (r < SAT_LO) begin
         r = SAT_LO;
      end
      return data_type'(r[15:0]);
   endfunction

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic push_pair(int a, int g);
      gelu_pair_type p;
      p.act  = data_type'(a);
      p.grad = data_type'(g);
      pairs_q.push_back(p);
   endtask

   task automatic fill_random();
      int a, g;
      for (int i = 0; i < N_RANDOM; i++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: a = $signed(16'($urandom));          // full range
            5, 6:          a = $urandom_range(0, 2000) + 19480; // near +tail
            7, 8:          a = -($urandom_range(0, 2000) + 19480);
            9:             a = int'($urandom_range(0, 511)) - 256;
            default:       a = int'($urandom_range(0, 40958)) - 20479;
         endcase
         case ($urandom_range(0, 9))
            0:       g = $urandom_range(0, 1) ? 32767 : -32768;
            1, 2:    g = int'($urandom_range(0, 8192)) - 4096;
            default: g = $signed(16'($urandom));
         endcase
         push_pair(a, g);
      end
   endtask

   // ------------------------------------------------------------------------
   // driver: bursts of random length separated by random gaps
   // ------------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(negedge clock) begin
      gelu_pair_type p;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_fired) begin
         // hold the item until it is taken
      end else if (gap_left > 0) begin
         req_ch.valid <= 1'b0;
         gap_left--;
      end else if (pairs_q.size() > 0) begin
         p = pairs_q.pop_front();
         req_ch.valid         <= 1'b1;
         req_ch.activation    <= p.act;
         req_ch.upstream_grad <= p.grad;
         burst_left--;
         if (burst_left <= 0) begin
            if ($urandom_range(0, 7) == 0) begin
               burst_left = $urandom_range(100, 300);
               gap_left   = 0;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = $urandom_range(0, 6);
            end
         end
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // response backpressure
   // ------------------------------------------------------------------------
   rdy_mode_type rdy_mode   = RDY_ALWAYS;
   int           mode_left  = 0;
   logic [7:0]   stall_mask = 8'hff;
   int           mask_pos   = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rdy_mode   = rdy_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 150);
            stall_mask = 8'($urandom) | 8'h01;
         end else begin
            mode_left--;
         end
         mask_pos = (mask_pos + 1) % 8;
         case (rdy_mode)
            RDY_ALWAYS:  rsp_ch.ready <= 1'b1;
            RDY_RANDOM:  rsp_ch.ready <= 1'($urandom);
            RDY_SPARSE:  rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            RDY_PATTERN: rsp_ch.ready <= stall_mask[mask_pos];
            default:     rsp_ch.ready <= 1'b1;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // monitor and checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      data_type want;
      bit       moved;
      moved     = 1'b0;
      req_fired = 1'b0;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            req_fired = 1'b1;
            moved     = 1'b1;
            grad_expected_q.push_back(gelu_grad_q412(req_ch.activation,
                                                     req_ch.upstream_grad));
            if (longint'(req_ch.activation) >= TAIL_X ||
                longint'(req_ch.activation) <= -TAIL_X) begin
               n_tail++;
            end
            n_accepted++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            if (grad_expected_q.size() == 0) begin
               $error("unexpected item on rsp_ch: input_grad %0d", rsp_ch.input_grad);
               n_errors++;
            end else begin
               want = grad_expected_q.pop_front();
               if (rsp_ch.input_grad !== want) begin
                  $error("input_grad mismatch: expected %0d, got %0d",
                         want, rsp_ch.input_grad);
                  n_errors++;
               end
               if (want == 16'sh7fff || want == 16'sh8000) begin
                  n_saturated++;
               end
               n_checked++;
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
      end
   end

   initial begin : watchdog
      @(negedge clock);
      while (idle_cycles < IDLE_LIMIT) begin
         @(negedge clock);
      end
      $display("timeout: no handshake for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, grad_expected_q.size());
      $display("== FAIL ==");
      $finish;
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.activation    = '0;
      req_ch.upstream_grad = '0;
      rsp_ch.ready         = 1'b0;
      n_accepted  = 0;
      n_checked   = 0;
      n_errors    = 0;
      n_saturated = 0;
      n_tail      = 0;
      idle_cycles = 0;
      req_fired   = 1'b0;

      build_tanh_knots();

      // directed: zero, tails and their edges, tanh range limit, saturation
      push_pair(0, 4096);
      push_pair(32767, 32767);
      push_pair(-32768, 32767);
      push_pair(-32768, -32768);
      push_pair(32767, -32768);
      push_pair(20480, 4096);
      push_pair(20479, 4096);
      push_pair(-20480, 4096);
      push_pair(-20479, 4096);
      push_pair(20275, -32768);   // |u| just past the table end
      push_pair(-20275, 32767);
      push_pair(6144, 32767);     // derivative above one: clamps high
      push_pair(6144, -32768);    // clamps low
      push_pair(1, 1);
      push_pair(-1, -1);
      push_pair(4096, 0);
      push_pair(-4096, 32767);
      push_pair(8192, 12345);
      push_pair(-3000, -20000);
      push_pair(0, -32768);
      push_pair(16000, 1);
      push_pair(-12288, -32768);
      fill_random();
      n_total = pairs_q.size();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (n_accepted < n_total || grad_expected_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (PIPE_LAT + 8) @(negedge clock);

      $display("%0d items sent, %0d results checked, %0d errors",
               n_accepted, n_checked, n_errors);
      $display("%0d items in the flat tails, %0d results at a saturation limit",
               n_tail, n_saturated);
      if (n_errors == 0 && grad_expected_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
